FILE: hw/rtl/pbms_pkg.sv
// Shared types, register codes and reset values for the power button motor sequencer.
// No dependencies; every RTL file refers to this package by scoped names.
package pbms_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int BATT_W      = 10;
    localparam int MODE_W      = 3;
    localparam int MODE_CNT_W  = 4;
    localparam int LIMIT_W     = 32;
    localparam int PRESS_W     = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_INDEX_W-1:0] CFG_INACTIVITY_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_POWER_ON_PRESS   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHUTDOWN_PRESS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RUN_ON           = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_GATE_ARM_DELAY   = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LOW_BATTERY      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MODE_COUNT       = 3'd6;

    // Register reset values
    localparam logic [LIMIT_W-1:0]    RST_INACTIVITY_LIMIT = 32'd180000;
    localparam logic [PRESS_W-1:0]    RST_POWER_ON_PRESS   = 16'd1500;
    localparam logic [PRESS_W-1:0]    RST_SHUTDOWN_PRESS   = 16'd3000;
    localparam logic [PRESS_W-1:0]    RST_RUN_ON           = 16'd3000;
    localparam logic [PRESS_W-1:0]    RST_GATE_ARM_DELAY   = 16'd500;
    localparam logic [BATT_W-1:0]     RST_LOW_BATTERY      = 10'd512;
    localparam logic [MODE_CNT_W-1:0] RST_MODE_COUNT       = 4'd3;

    localparam logic [MODE_CNT_W-1:0] MODE_CNT_MAX = 4'd8;

    typedef enum logic [1:0] {
        ST_OFF    = 2'd0,
        ST_IDLE   = 2'd1,
        ST_ACTIVE = 2'd2
    } main_state_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]    inactivity_limit_ms;
        logic [PRESS_W-1:0]    power_on_press_ms;
        logic [PRESS_W-1:0]    shutdown_press_ms;
        logic [PRESS_W-1:0]    run_on_ms;
        logic [PRESS_W-1:0]    gate_arm_delay_ms;
        logic [BATT_W-1:0]     low_battery_level;
        logic [MODE_CNT_W-1:0] mode_count;
    } cfg_t;

    typedef struct packed {
        logic              kind;
        logic              power_key_level;
        logic              func_key_level;
        logic              sensor_level;
        logic              power_key_edge;
        logic              func_key_edge;
        logic              sensor_edge;
        logic [BATT_W-1:0] battery_sample;
    } item_t;

    typedef struct packed {
        logic [1:0]        main_state;
        logic              powered;
        logic              motor_drive;
        logic              sensor_power;
        logic              sensor_armed;
        logic [MODE_W-1:0] rotation_mode;
        logic              speed_step;
        logic              low_battery_alarm;
        logic              converter_enable;
    } result_t;

    // (idx + 1) mod count, count clamped to 1..8; at most eight subtract steps
    function automatic logic [MODE_W-1:0] mode_wrap(
        input logic [MODE_W-1:0]     idx,
        input logic [MODE_CNT_W-1:0] count
    );
        logic [MODE_CNT_W-1:0] mc;
        logic [MODE_CNT_W-1:0] r;
        begin
            if (count == '0)
                mc = MODE_CNT_W'(1);
            else if (count > MODE_CNT_MAX)
                mc = MODE_CNT_MAX;
            else
                mc = count;
            r = MODE_CNT_W'(idx) + MODE_CNT_W'(1);
            for (int i = 0; i < 8; i++)
            begin
                if (r >= mc)
                    r = r - mc;
            end
            return r[MODE_W-1:0];
        end
    endfunction

endpackage

FILE: hw/rtl/power_button_motor_sequencer_core.sv
// Power button motor sequencer, top level: input register, sequencer core, result register.
// An accepted item waits in the input register; its result is registered in the result register.
// One item per cycle while out_ready is high; an empty input register fills while a result waits.
// Reset (rst_n, async, active low): unit off, timestamps invalid, time zero, registers
// at their documented defaults; both stages empty. No clearing pass.
// Depends on pbms_pkg, pbms_cfg and pbms_core.
module power_button_motor_sequencer_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,

    // input item channel
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic                                power_key_level,
    input  logic                                func_key_level,
    input  logic                                sensor_level,
    input  logic                                power_key_edge,
    input  logic                                func_key_edge,
    input  logic                                sensor_edge,
    input  logic [pbms_pkg::BATT_W-1:0]         battery_sample,

    // result channel
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [1:0]                          main_state,
    output logic                                powered,
    output logic                                motor_drive,
    output logic                                sensor_power,
    output logic                                sensor_armed,
    output logic [pbms_pkg::MODE_W-1:0]         rotation_mode,
    output logic                                speed_step,
    output logic                                low_battery_alarm,
    output logic                                converter_enable,

    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [pbms_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pbms_pkg::CFG_DATA_W-1:0]     cfg_data
);

    pbms_pkg::cfg_t     cfg;
    pbms_pkg::item_t    item_reg;
    pbms_pkg::item_t    item_in;
    pbms_pkg::result_t  res;
    pbms_pkg::result_t  res_reg;
    logic               in_full_reg;
    logic               in_full_next;
    logic               out_full_reg;
    logic               out_full_next;
    logic               in_xfer;
    logic               fire;

    // Config writes are always taken; software writes only while the block is idle (not enforced here).
    assign cfg_ready = 1'b1;

    pbms_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    assign item_in = '{
        kind:            kind,
        power_key_level: power_key_level,
        func_key_level:  func_key_level,
        sensor_level:    sensor_level,
        power_key_edge:  power_key_edge,
        func_key_edge:   func_key_edge,
        sensor_edge:     sensor_edge,
        battery_sample:  battery_sample
    };

    // The held item is processed when the result register is free or being drained.
    // State in the core advances only on that cycle, so stalls never repeat an item.
    assign fire     = in_full_reg && (!out_full_reg || out_ready);
    assign in_ready = !in_full_reg || fire;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        if (in_xfer)
            in_full_next = 1'b1;
        else if (fire)
            in_full_next = 1'b0;
        else
            in_full_next = in_full_reg;

        if (fire)
            out_full_next = 1'b1;
        else if (out_ready)
            out_full_next = 1'b0;
        else
            out_full_next = out_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            item_reg <= item_in;
        if (fire)
            res_reg <= res;
    end

    pbms_core #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .item  (item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    assign out_valid         = out_full_reg;
    assign main_state        = res_reg.main_state;
    assign powered           = res_reg.powered;
    assign motor_drive       = res_reg.motor_drive;
    assign sensor_power      = res_reg.sensor_power;
    assign sensor_armed      = res_reg.sensor_armed;
    assign rotation_mode     = res_reg.rotation_mode;
    assign speed_step        = res_reg.speed_step;
    assign low_battery_alarm = res_reg.low_battery_alarm;
    assign converter_enable  = res_reg.converter_enable;

endmodule

FILE: hw/rtl/pbms_cfg.sv
// Configuration register file for the power button motor sequencer.
// Depends on pbms_pkg (cfg_t, register indexes, reset values).
module pbms_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [pbms_pkg::CFG_INDEX_W-1:0]   wr_index,
    input  logic [pbms_pkg::CFG_DATA_W-1:0]    wr_data,
    output pbms_pkg::cfg_t                     cfg
);

    pbms_pkg::cfg_t cfg_reg;
    pbms_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                pbms_pkg::CFG_INACTIVITY_LIMIT:
                    cfg_next.inactivity_limit_ms = wr_data[pbms_pkg::LIMIT_W-1:0];
                pbms_pkg::CFG_POWER_ON_PRESS:
                    cfg_next.power_on_press_ms = wr_data[pbms_pkg::PRESS_W-1:0];
                pbms_pkg::CFG_SHUTDOWN_PRESS:
                    cfg_next.shutdown_press_ms = wr_data[pbms_pkg::PRESS_W-1:0];
                pbms_pkg::CFG_RUN_ON:
                    cfg_next.run_on_ms = wr_data[pbms_pkg::PRESS_W-1:0];
                pbms_pkg::CFG_GATE_ARM_DELAY:
                    cfg_next.gate_arm_delay_ms = wr_data[pbms_pkg::PRESS_W-1:0];
                pbms_pkg::CFG_LOW_BATTERY:
                    cfg_next.low_battery_level = wr_data[pbms_pkg::BATT_W-1:0];
                pbms_pkg::CFG_MODE_COUNT:
                    cfg_next.mode_count = wr_data[pbms_pkg::MODE_CNT_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inactivity_limit_ms <= pbms_pkg::RST_INACTIVITY_LIMIT;
            cfg_reg.power_on_press_ms   <= pbms_pkg::RST_POWER_ON_PRESS;
            cfg_reg.shutdown_press_ms   <= pbms_pkg::RST_SHUTDOWN_PRESS;
            cfg_reg.run_on_ms           <= pbms_pkg::RST_RUN_ON;
            cfg_reg.gate_arm_delay_ms   <= pbms_pkg::RST_GATE_ARM_DELAY;
            cfg_reg.low_battery_level   <= pbms_pkg::RST_LOW_BATTERY;
            cfg_reg.mode_count          <= pbms_pkg::RST_MODE_COUNT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/pbms_core.sv
// Sequencer state registers and the single-pass next-state logic for one item.
// Depends on pbms_pkg (item_t, cfg_t, result_t, main_state_t, mode_wrap).
module pbms_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  pbms_pkg::item_t     item,
    input  pbms_pkg::cfg_t      cfg,
    output pbms_pkg::result_t   res
);

    // compare width: wide enough for both the time difference and a 32-bit duration
    localparam int CW = (TIME_WIDTH > pbms_pkg::LIMIT_W) ? TIME_WIDTH : pbms_pkg::LIMIT_W;

    typedef logic [TIME_WIDTH-1:0] stamp_at_t;

    // wrapped difference, zero-extended, against the duration
    function automatic logic elapsed(
        input stamp_at_t        now_t,
        input stamp_at_t        since,
        input logic [CW-1:0]    dur
    );
        stamp_at_t     diff;
        logic [CW-1:0] wide;
        begin
            diff = now_t - since;
            wide = CW'(diff);
            return wide >= dur;
        end
    endfunction

    stamp_at_t                  time_reg,       time_next;
    stamp_at_t                  activity_reg,   activity_next;
    pbms_pkg::main_state_t      state_reg,      state_next;
    logic                       power_reg,      power_next;
    logic                       armed_reg,      armed_next;
    logic                       alarm_reg,      alarm_next;
    logic [pbms_pkg::MODE_W-1:0] mode_reg,      mode_next;
    logic                       on_vld_reg,     on_vld_next;
    stamp_at_t                  on_at_reg,      on_at_next;
    logic                       off_vld_reg,    off_vld_next;
    stamp_at_t                  off_at_reg,     off_at_next;
    logic                       pp_vld_reg,     pp_vld_next;
    stamp_at_t                  pp_at_reg,      pp_at_next;
    logic                       fp_vld_reg,     fp_vld_next;
    stamp_at_t                  fp_at_reg,      fp_at_next;
    logic                       speed_pulse;
    logic                       conv_pulse;

    always_comb
    begin
        time_next     = time_reg;
        activity_next = activity_reg;
        state_next    = state_reg;
        power_next    = power_reg;
        armed_next    = armed_reg;
        alarm_next    = alarm_reg;
        mode_next     = mode_reg;
        on_vld_next   = on_vld_reg;
        on_at_next    = on_at_reg;
        off_vld_next  = off_vld_reg;
        off_at_next   = off_at_reg;
        pp_vld_next   = pp_vld_reg;
        pp_at_next    = pp_at_reg;
        fp_vld_next   = fp_vld_reg;
        fp_at_next    = fp_at_reg;
        speed_pulse   = 1'b0;
        conv_pulse    = 1'b0;

        // time base and event stamping
        if (!item.kind)
        begin
            time_next = time_reg + TIME_WIDTH'(1);
        end
        else
        begin
            activity_next = time_reg;
            if (item.power_key_edge && item.power_key_level)
            begin
                pp_vld_next = 1'b1;
                pp_at_next  = time_reg;
            end
            if (item.func_key_edge && item.func_key_level)
            begin
                fp_vld_next = 1'b1;
                fp_at_next  = time_reg;
            end
            if (armed_reg && item.sensor_edge && item.sensor_level)
            begin
                on_vld_next  = 1'b1;
                on_at_next   = time_reg;
                off_vld_next = 1'b0;
            end
        end

        // power key: long hold powers on or off, release is a short press
        if (pp_vld_next)
        begin
            if (item.power_key_level)
            begin
                if (state_next == pbms_pkg::ST_OFF)
                begin
                    if (elapsed(time_next, pp_at_next, CW'(cfg.power_on_press_ms)))
                    begin
                        power_next    = 1'b1;
                        activity_next = time_next;
                    end
                end
                else if (elapsed(time_next, pp_at_next, CW'(cfg.shutdown_press_ms)))
                begin
                    power_next   = 1'b0;
                    armed_next   = 1'b0;
                    alarm_next   = 1'b0;
                    off_vld_next = 1'b0;
                    pp_vld_next  = 1'b0;
                    state_next   = pbms_pkg::ST_OFF;
                end
            end
            else
            begin
                pp_vld_next = 1'b0;
                if (state_next != pbms_pkg::ST_OFF)
                begin
                    speed_pulse   = 1'b1;
                    activity_next = time_next;
                end
            end
        end

        // function key steps the rotation mode
        if (state_next != pbms_pkg::ST_OFF && fp_vld_next && item.func_key_level)
        begin
            mode_next   = pbms_pkg::mode_wrap(mode_reg, cfg.mode_count);
            fp_vld_next = 1'b0;
        end

        case (state_next)
            pbms_pkg::ST_OFF:
            begin
                // boot check
                if (power_next)
                begin
                    conv_pulse = 1'b1;
                    alarm_next = item.battery_sample < cfg.low_battery_level;
                    state_next = pbms_pkg::ST_IDLE;
                    armed_next = 1'b0;
                end
            end
            pbms_pkg::ST_IDLE:
            begin
                if (elapsed(time_next, activity_next, CW'(cfg.inactivity_limit_ms)))
                begin
                    power_next   = 1'b0;
                    armed_next   = 1'b0;
                    alarm_next   = 1'b0;
                    off_vld_next = 1'b0;
                    pp_vld_next  = 1'b0;
                    state_next   = pbms_pkg::ST_OFF;
                end
                else
                begin
                    if (!armed_next &&
                        elapsed(time_next, activity_next, CW'(cfg.gate_arm_delay_ms)))
                        armed_next = 1'b1;
                    if (on_vld_next)
                        state_next = pbms_pkg::ST_ACTIVE;
                end
            end
            pbms_pkg::ST_ACTIVE:
            begin
                // run-on: stamp the clear, fall back to idle once it has elapsed
                if (!item.sensor_level && !off_vld_next)
                begin
                    off_vld_next = 1'b1;
                    off_at_next  = time_next;
                    on_vld_next  = 1'b0;
                end
                if (off_vld_next && elapsed(time_next, off_at_next, CW'(cfg.run_on_ms)))
                begin
                    off_vld_next = 1'b0;
                    state_next   = pbms_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase

        res.main_state        = state_next;
        res.powered           = power_next;
        res.motor_drive       = (state_next == pbms_pkg::ST_ACTIVE);
        res.sensor_power      = (state_next != pbms_pkg::ST_OFF);
        res.sensor_armed      = armed_next;
        res.rotation_mode     = mode_next;
        res.speed_step        = speed_pulse;
        res.low_battery_alarm = alarm_next;
        res.converter_enable  = conv_pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_reg     <= '0;
            activity_reg <= '0;
            state_reg    <= pbms_pkg::ST_OFF;
            power_reg    <= 1'b0;
            armed_reg    <= 1'b0;
            alarm_reg    <= 1'b0;
            mode_reg     <= '0;
            on_vld_reg   <= 1'b0;
            off_vld_reg  <= 1'b0;
            pp_vld_reg   <= 1'b0;
            fp_vld_reg   <= 1'b0;
        end
        else if (fire)
        begin
            time_reg     <= time_next;
            activity_reg <= activity_next;
            state_reg    <= state_next;
            power_reg    <= power_next;
            armed_reg    <= armed_next;
            alarm_reg    <= alarm_next;
            mode_reg     <= mode_next;
            on_vld_reg   <= on_vld_next;
            off_vld_reg  <= off_vld_next;
            pp_vld_reg   <= pp_vld_next;
            fp_vld_reg   <= fp_vld_next;
        end
    end

    // stamp values are qualified by their valid bits
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            on_at_reg  <= on_at_next;
            off_at_reg <= off_at_next;
            pp_at_reg  <= pp_at_next;
            fp_at_reg  <= fp_at_next;
        end
    end

endmodule
